FILE: rtl/fprx_pkg.sv
// Shared types and constants for the framed packet receiver.
package fprx_pkg;

  localparam int TBL_ENTRIES = 16;
  localparam int TBL_AW      = $clog2(TBL_ENTRIES);
  localparam int STG_BYTES   = 32;
  localparam int STG_AW      = $clog2(STG_BYTES);
  localparam int CNT_W       = $clog2(STG_BYTES + 1);
  localparam int LEN_MAX     = (2 * TBL_ENTRIES < STG_BYTES) ? 2 * TBL_ENTRIES : STG_BYTES;
  localparam int CFG_AW      = 4;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  localparam logic [7:0] RST_START_BYTE = 8'd126;
  localparam logic [7:0] RST_END_BYTE   = 8'd127;
  localparam logic [7:0] RST_TIMEOUT    = 8'd10;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ACCEPTED = 3'd1,
    ST_TIMEOUT  = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_CRC_ERR  = 3'd4,
    ST_END_ERR  = 3'd5,
    ST_DISCARD  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    REG_START   = 2'd0,
    REG_END     = 2'd1,
    REG_TIMEOUT = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CRC     = 3'd3,
    PH_END     = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_CRC,
    SQ_CMT_ID,
    SQ_CMT_VAL,
    SQ_CMT_WR,
    SQ_DONE
  } seq_t;

  typedef struct packed {
    logic       we;
    logic [TBL_AW-1:0] waddr;
    logic [7:0] wdata;
  } tbl_wr_t;

endpackage

FILE: rtl/fprx_crc_unit.sv
// Bit-serial reflected CRC-8 unit: one bit per cycle.
module fprx_crc_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] crc_in,
  input  logic [7:0] data_in,
  output logic       done,
  output logic [7:0] crc_out
);

  logic       busy_r;
  logic [2:0] cnt_r;
  logic [7:0] crc_r;
  logic [7:0] data_r;
  logic       done_r;
  logic       mix;

  assign mix = crc_r[0] ^ data_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      crc_r  <= crc_in;
      data_r <= data_in;
    end else if (busy_r) begin
      crc_r  <= (crc_r >> 1) ^ (mix ? fprx_pkg::CRC_POLY : 8'h00);
      data_r <= data_r >> 1;
    end
  end

  assign done    = done_r;
  assign crc_out = crc_r;

endmodule

FILE: rtl/fprx_value_table.sv
// Value table: flip-flop entries cleared at reset, one write and one read port.
module fprx_value_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fprx_pkg::tbl_wr_t           wr,
  input  logic [fprx_pkg::TBL_AW-1:0] rd_addr,
  output logic [7:0]                  rd_data
);

  logic [7:0] entry_r [fprx_pkg::TBL_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fprx_pkg::TBL_ENTRIES; i++) begin
        entry_r[i[fprx_pkg::TBL_AW-1:0]] <= 8'h00;
      end
    end else if (wr.we) begin
      entry_r[wr.waddr] <= wr.wdata;
    end
  end

  assign rd_data = entry_r[rd_addr];

endmodule

FILE: rtl/framed_packet_receiver_crc8.sv
// Top level: framed serial packet receiver with CRC-8 check and value table.
// Each transaction carries one operation: a received byte, a time tick or a
// table read, and gives exactly one result (status, read_value). Reads, ticks
// and non-payload bytes are settled when accepted and then passed on to the
// result. A payload byte is written to the staging memory and fed to the
// bit-serial CRC unit, which advances one bit per cycle; the new CRC is then
// written back and the result given. A matching end byte of a non-empty frame
// commits the staged pairs, each id/value pair by two reads of the staging
// memory, which has one read port, and one table write. in_stall is high
// while an operation is in progress; one result register lets the next
// transaction be accepted while the previous result waits on out_stall.
module framed_packet_receiver_crc8 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_operation,
  input  logic [7:0]                    in_rx_byte,
  input  logic [3:0]                    in_read_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic [7:0]                    out_read_value,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [fprx_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  // configuration registers
  logic [7:0] start_byte_r, end_byte_r, timeout_r;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= fprx_pkg::RST_START_BYTE;
      end_byte_r   <= fprx_pkg::RST_END_BYTE;
      timeout_r    <= fprx_pkg::RST_TIMEOUT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        fprx_pkg::REG_START:   start_byte_r <= cfg_pwdata[7:0];
        fprx_pkg::REG_END:     end_byte_r   <= cfg_pwdata[7:0];
        fprx_pkg::REG_TIMEOUT: timeout_r    <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      fprx_pkg::REG_START:   cfg_prdata = {24'h0, start_byte_r};
      fprx_pkg::REG_END:     cfg_prdata = {24'h0, end_byte_r};
      fprx_pkg::REG_TIMEOUT: cfg_prdata = {24'h0, timeout_r};
      default:               cfg_prdata = 32'h0;
    endcase
  end

  // sequencer and frame state
  fprx_pkg::seq_t   seq_r, seq_nxt;
  fprx_pkg::phase_t phase_r, phase_nxt;
  logic [fprx_pkg::CNT_W-1:0] flen_r, flen_nxt;
  logic [fprx_pkg::CNT_W-1:0] bcnt_r, bcnt_nxt;
  logic [fprx_pkg::CNT_W-1:0] cidx_r, cidx_nxt;
  logic [7:0] rcrc_r, rcrc_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic [7:0] id_r, id_nxt;
  logic [2:0] res_status_r, res_status_nxt;
  logic [7:0] res_value_r, res_value_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  logic [7:0] out_value_r, out_value_nxt;

  logic accept, out_free;
  logic crc_start, crc_done;
  logic [7:0] crc_out;
  logic [fprx_pkg::CNT_W-1:0] bcnt_inc, cidx_inc;
  logic [7:0] tick_sat;

  // staging memory
  logic [7:0] stg_mem [fprx_pkg::STG_BYTES];
  logic       stg_we, stg_re;
  logic [fprx_pkg::STG_AW-1:0] stg_waddr, stg_raddr;
  logic [7:0] stg_rdata_r;

  fprx_pkg::tbl_wr_t tbl_wr;
  logic [7:0]        tbl_rdata;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (seq_r != fprx_pkg::SQ_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign bcnt_inc = bcnt_r + fprx_pkg::CNT_W'(1);
  assign cidx_inc = cidx_r + fprx_pkg::CNT_W'(2);
  assign tick_sat = (tick_r == 8'hFF) ? tick_r : tick_r + 8'd1;

  always_ff @(posedge clk) begin
    if (stg_we) begin
      stg_mem[stg_waddr] <= in_rx_byte;
    end
    if (stg_re) begin
      stg_rdata_r <= stg_mem[stg_raddr];
    end
  end

  fprx_crc_unit u_crc (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (crc_start),
    .crc_in  (rcrc_r),
    .data_in (in_rx_byte),
    .done    (crc_done),
    .crc_out (crc_out)
  );

  fprx_value_table u_tbl (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .rd_addr (fprx_pkg::TBL_AW'(in_read_index)),
    .rd_data (tbl_rdata)
  );

  // next state of the sequencer
  always_comb begin
    seq_nxt = seq_r;
    case (seq_r)
      fprx_pkg::SQ_IDLE: begin
        if (accept) begin
          seq_nxt = fprx_pkg::SQ_DONE;
          if (fprx_pkg::op_t'(in_operation) == fprx_pkg::OP_BYTE) begin
            if (phase_r == fprx_pkg::PH_PAYLOAD) begin
              seq_nxt = fprx_pkg::SQ_CRC;
            end else if (phase_r == fprx_pkg::PH_END && in_rx_byte == end_byte_r &&
                         flen_r != '0) begin
              seq_nxt = fprx_pkg::SQ_CMT_ID;
            end
          end
        end
      end
      fprx_pkg::SQ_CRC:     if (crc_done) seq_nxt = fprx_pkg::SQ_DONE;
      fprx_pkg::SQ_CMT_ID:  seq_nxt = fprx_pkg::SQ_CMT_VAL;
      fprx_pkg::SQ_CMT_VAL: seq_nxt = fprx_pkg::SQ_CMT_WR;
      fprx_pkg::SQ_CMT_WR: begin
        seq_nxt = (cidx_inc >= flen_r) ? fprx_pkg::SQ_DONE : fprx_pkg::SQ_CMT_ID;
      end
      fprx_pkg::SQ_DONE:    if (out_free) seq_nxt = fprx_pkg::SQ_IDLE;
      default:              seq_nxt = fprx_pkg::SQ_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_nxt      = phase_r;
    flen_nxt       = flen_r;
    bcnt_nxt       = bcnt_r;
    cidx_nxt       = cidx_r;
    rcrc_nxt       = rcrc_r;
    tick_nxt       = tick_r;
    id_nxt         = id_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    crc_start      = 1'b0;
    stg_we         = 1'b0;
    stg_waddr      = bcnt_r[fprx_pkg::STG_AW-1:0];
    stg_re         = 1'b0;
    stg_raddr      = cidx_r[fprx_pkg::STG_AW-1:0];
    tbl_wr.we      = 1'b0;
    tbl_wr.waddr   = id_r[fprx_pkg::TBL_AW-1:0];
    tbl_wr.wdata   = stg_rdata_r;

    case (seq_r)
      fprx_pkg::SQ_IDLE: begin
        if (accept) begin
          res_status_nxt = fprx_pkg::ST_OK;
          res_value_nxt  = 8'h00;
          case (fprx_pkg::op_t'(in_operation))
            fprx_pkg::OP_BYTE: begin
              case (phase_r)
                fprx_pkg::PH_HUNT: begin
                  if (in_rx_byte == start_byte_r) begin
                    phase_nxt = fprx_pkg::PH_LEN;
                    tick_nxt  = 8'h00;
                  end else begin
                    res_status_nxt = fprx_pkg::ST_DISCARD;
                  end
                end
                fprx_pkg::PH_LEN: begin
                  if (in_rx_byte[0] || 32'(in_rx_byte) > fprx_pkg::LEN_MAX) begin
                    phase_nxt      = fprx_pkg::PH_HUNT;
                    res_status_nxt = fprx_pkg::ST_BAD_LEN;
                  end else begin
                    flen_nxt  = fprx_pkg::CNT_W'(in_rx_byte);
                    bcnt_nxt  = '0;
                    rcrc_nxt  = 8'h00;
                    phase_nxt = (in_rx_byte == 8'h00) ? fprx_pkg::PH_CRC
                                                      : fprx_pkg::PH_PAYLOAD;
                  end
                end
                fprx_pkg::PH_PAYLOAD: begin
                  stg_we    = 1'b1;
                  crc_start = 1'b1;
                  bcnt_nxt  = bcnt_inc;
                  if (bcnt_inc >= flen_r) phase_nxt = fprx_pkg::PH_CRC;
                end
                fprx_pkg::PH_CRC: begin
                  if (in_rx_byte != rcrc_r) begin
                    phase_nxt      = fprx_pkg::PH_HUNT;
                    res_status_nxt = fprx_pkg::ST_CRC_ERR;
                  end else begin
                    phase_nxt = fprx_pkg::PH_END;
                  end
                end
                fprx_pkg::PH_END: begin
                  phase_nxt = fprx_pkg::PH_HUNT;
                  if (in_rx_byte != end_byte_r) begin
                    res_status_nxt = fprx_pkg::ST_END_ERR;
                  end else begin
                    res_status_nxt = fprx_pkg::ST_ACCEPTED;
                    cidx_nxt       = '0;
                  end
                end
                default: phase_nxt = fprx_pkg::PH_HUNT;
              endcase
            end
            fprx_pkg::OP_TICK: begin
              if (phase_r != fprx_pkg::PH_HUNT) begin
                tick_nxt = tick_sat;
                if (tick_sat >= timeout_r) begin
                  phase_nxt      = fprx_pkg::PH_HUNT;
                  res_status_nxt = fprx_pkg::ST_TIMEOUT;
                end
              end
            end
            fprx_pkg::OP_READ: begin
              if (32'(in_read_index) < fprx_pkg::TBL_ENTRIES) res_value_nxt = tbl_rdata;
            end
            default: ;
          endcase
        end
      end
      fprx_pkg::SQ_CRC: begin
        if (crc_done) rcrc_nxt = crc_out;
      end
      fprx_pkg::SQ_CMT_ID: begin
        stg_re = 1'b1;
      end
      fprx_pkg::SQ_CMT_VAL: begin
        // id arrives now; fetch its value
        id_nxt    = stg_rdata_r;
        stg_re    = 1'b1;
        stg_raddr = cidx_r[fprx_pkg::STG_AW-1:0] + fprx_pkg::STG_AW'(1);
      end
      fprx_pkg::SQ_CMT_WR: begin
        tbl_wr.we = (32'(id_r) < fprx_pkg::TBL_ENTRIES);
        cidx_nxt  = cidx_inc;
      end
      fprx_pkg::SQ_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= fprx_pkg::SQ_IDLE;
      phase_r     <= fprx_pkg::PH_HUNT;
      flen_r      <= '0;
      bcnt_r      <= '0;
      cidx_r      <= '0;
      rcrc_r      <= 8'h00;
      tick_r      <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      phase_r     <= phase_nxt;
      flen_r      <= flen_nxt;
      bcnt_r      <= bcnt_nxt;
      cidx_r      <= cidx_nxt;
      rcrc_r      <= rcrc_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r         <= id_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_value_r;

endmodule
